/* design/bmp24_pkg.sv */
// shared types and constants of the 24-bit bmp stream decoder
`timescale 1ns / 1ps
`default_nettype none

package bmp24_pkg;

  // image size limits, fixed by the 12-bit row and column fields
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = $clog2(MAX_WIDTH);

  // header layout, byte positions of the last byte of each checked field
  localparam int         POS_W         = 6;
  localparam logic [5:0] POS_MAGIC     = 6'd1;
  localparam logic [5:0] POS_INFO_SIZE = 6'd17;
  localparam logic [5:0] POS_WIDTH     = 6'd21;
  localparam logic [5:0] POS_HEIGHT    = 6'd25;
  localparam logic [5:0] POS_PLANES    = 6'd27;
  localparam logic [5:0] POS_COMPRESS  = 6'd33;
  localparam logic [5:0] POS_HDR_LAST  = 6'd53;

  localparam logic [15:0] MAGIC_LE  = 16'h4D42;
  localparam logic [31:0] INFO_SIZE = 32'd40;
  localparam logic [15:0] ONE_PLANE = 16'd1;

  // result status codes
  localparam logic [2:0] ST_PIXEL        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC    = 3'd1;
  localparam logic [2:0] ST_BAD_HDR_SIZE = 3'd2;
  localparam logic [2:0] ST_BAD_PLANES   = 3'd3;
  localparam logic [2:0] ST_COMPRESSED   = 3'd4;
  localparam logic [2:0] ST_BAD_SIZE     = 3'd5;
  localparam logic [2:0] ST_PAD_NONZERO  = 3'd6;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [DIM_W-1:0] out_row;
    logic [DIM_W-1:0] out_column;
    logic             last_pixel;
    logic [2:0]       status;
  } out_word_t;

  // header parser to pixel stage and control
  typedef struct packed {
    logic             done;
    logic             err;
    logic [2:0]       err_code;
    logic [DIM_W-1:0] width_m1;
    logic [DIM_W-1:0] height_m1;
    logic [1:0]       pad_bytes;
  } hdr_info_t;

  // pixel stage to control
  typedef struct packed {
    logic emit;
    logic row_end;
    logic last;
    logic pad_done;
  } pix_info_t;

endpackage

`default_nettype wire

/* design/bmp24_hdr.sv */
// header parser: field accumulator, byte position, checks and image geometry
`timescale 1ns / 1ps
`default_nettype none

module bmp24_hdr (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 restart,
  input  wire logic [7:0]           file_byte,
  output bmp24_pkg::hdr_info_t      info
);

  logic [bmp24_pkg::POS_W-1:0]   pos_r, pos_nxt, pos_eff;
  logic [31:0]                   acc_r, acc_nxt, acc_eff;
  logic [bmp24_pkg::DIM_W-1:0]   width_m1_r, width_m1_nxt;
  logic [bmp24_pkg::DIM_W-1:0]   height_m1_r, height_m1_nxt;
  logic [1:0]                    pad_r, pad_nxt;
  logic                          width_ok_r, width_ok_nxt;
  logic                          height_ok;
  logic [bmp24_pkg::DIM_W-1:0]   acc_m1;

  assign pos_eff = restart ? '0 : pos_r;
  assign acc_eff = restart ? '0 : acc_r;
  assign acc_nxt = {file_byte, acc_eff[31:8]};
  // only in-range sizes are kept, so the low bits carry the whole value minus one
  assign acc_m1  = acc_nxt[bmp24_pkg::DIM_W-1:0] - (bmp24_pkg::DIM_W)'(1);
  assign pos_nxt = pos_eff + (bmp24_pkg::POS_W)'(1);

  assign height_ok = (acc_nxt != 32'd0) &&
                     (acc_nxt <= 32'(bmp24_pkg::MAX_HEIGHT));

  always_comb begin
    width_m1_nxt  = width_m1_r;
    width_ok_nxt  = width_ok_r;
    pad_nxt       = pad_r;
    height_m1_nxt = height_m1_r;
    info          = '0;
    info.width_m1  = width_m1_r;
    info.height_m1 = height_m1_r;
    info.pad_bytes = pad_r;
    if (pos_eff == bmp24_pkg::POS_WIDTH) begin
      width_m1_nxt = acc_m1;
      pad_nxt      = acc_nxt[1:0];
      width_ok_nxt = (acc_nxt != 32'd0) && (acc_nxt <= 32'(bmp24_pkg::MAX_WIDTH));
    end
    if (pos_eff == bmp24_pkg::POS_HEIGHT) begin
      height_m1_nxt = acc_m1;
    end
    priority if (pos_eff == bmp24_pkg::POS_MAGIC && acc_nxt[31:16] != bmp24_pkg::MAGIC_LE) begin
      info.err      = 1'b1;
      info.err_code = bmp24_pkg::ST_BAD_MAGIC;
    end else if (pos_eff == bmp24_pkg::POS_INFO_SIZE && acc_nxt != bmp24_pkg::INFO_SIZE) begin
      info.err      = 1'b1;
      info.err_code = bmp24_pkg::ST_BAD_HDR_SIZE;
    end else if (pos_eff == bmp24_pkg::POS_HEIGHT && (!width_ok_r || !height_ok)) begin
      info.err      = 1'b1;
      info.err_code = bmp24_pkg::ST_BAD_SIZE;
    end else if (pos_eff == bmp24_pkg::POS_PLANES && acc_nxt[31:16] != bmp24_pkg::ONE_PLANE) begin
      info.err      = 1'b1;
      info.err_code = bmp24_pkg::ST_BAD_PLANES;
    end else if (pos_eff == bmp24_pkg::POS_COMPRESS && acc_nxt != 32'd0) begin
      info.err      = 1'b1;
      info.err_code = bmp24_pkg::ST_COMPRESSED;
    end else if (pos_eff == bmp24_pkg::POS_HDR_LAST) begin
      info.done = 1'b1;
    end else begin
      info.done = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      acc_r      <= '0;
      width_ok_r <= 1'b0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      width_ok_r  <= width_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      width_m1_r  <= width_m1_nxt;
      height_m1_r <= height_m1_nxt;
      pad_r       <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/bmp24_pix.sv */
// pixel assembly: channel gathering, column and row counters, padding count
`timescale 1ns / 1ps
`default_nettype none

module bmp24_pix (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic                 step_pix,
  input  wire logic                 step_pad,
  input  wire logic [7:0]           file_byte,
  input  wire bmp24_pkg::hdr_info_t hdr,
  output bmp24_pkg::pix_info_t      info,
  output bmp24_pkg::out_word_t      pixel
);

  logic [1:0]                    chan_r;
  logic [7:0]                    blue_r, green_r;
  logic [bmp24_pkg::DIM_W-1:0]   col_r, row_r;
  logic [1:0]                    pad_left_r;

  assign info.emit     = step_pix && (chan_r == 2'd2);
  assign info.row_end  = (col_r == hdr.width_m1);
  assign info.last     = info.row_end && (row_r == hdr.height_m1);
  assign info.pad_done = (pad_left_r == 2'd1);

  always_comb begin
    pixel            = '0;
    pixel.red        = file_byte;
    pixel.green      = green_r;
    pixel.blue       = blue_r;
    pixel.out_row    = hdr.height_m1 - row_r;
    pixel.out_column = col_r;
    pixel.last_pixel = info.last;
    pixel.status     = bmp24_pkg::ST_PIXEL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pad_left_r <= '0;
    end else if (load) begin
      chan_r     <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pad_left_r <= '0;
    end else if (step_pix) begin
      unique case (chan_r)
        2'd0: chan_r <= 2'd1;
        2'd1: chan_r <= 2'd2;
        default: begin
          chan_r <= 2'd0;
          if (info.row_end) begin
            col_r      <= '0;
            pad_left_r <= hdr.pad_bytes;
            if (!info.last) begin
              row_r <= row_r + (bmp24_pkg::DIM_W)'(1);
            end
          end else begin
            col_r <= col_r + (bmp24_pkg::DIM_W)'(1);
          end
        end
      endcase
    end else if (step_pad) begin
      pad_left_r <= pad_left_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_pix && chan_r == 2'd0) begin
      blue_r <= file_byte;
    end
    if (step_pix && chan_r == 2'd1) begin
      green_r <= file_byte;
    end
  end

endmodule

`default_nettype wire

/* design/bmp24_24bit_stream_decoder_core.sv */
// top level of the 24-bit bmp stream decoder: phase control and result register
`timescale 1ns / 1ps
`default_nettype none

//  channel   ports                          word
//  input     in_valid  in_ready  in_word    file_byte, start_of_file
//  result    out_valid out_ready out_word   red, green, blue, out_row, out_column,
//                                           last_pixel, status
//
// one file byte is taken every cycle while in_ready is high; the result of a byte
// appears in the result register in the cycle after it is accepted
// a byte is accepted whenever the result register is empty or is being taken,
// so a stall on the result side holds the input for exactly as long
// rst_n (synchronous) returns to the header phase at byte 0; a start flag
// does the same for the byte that carries it

module bmp_24bit_stream_decoder_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire bmp24_pkg::in_word_t  in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output bmp24_pkg::out_word_t      out_word
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PIXELS,
    PH_PAD,
    PH_TAIL_PAD,
    PH_DONE,
    PH_HALTED
  } phase_t;

  phase_t                phase_r, phase_nxt, phase_eff;
  logic                  out_valid_r, res_valid;
  bmp24_pkg::out_word_t  out_word_r, res_word, pixel;
  bmp24_pkg::hdr_info_t  hdr;
  bmp24_pkg::pix_info_t  pix;
  logic                  accept, restart;
  logic                  step_hdr, step_pix, step_pad;

  // result register is free when empty or drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign restart   = accept && in_word.start_of_file;

  // a start flag sends the flagged byte straight into header byte 0
  assign phase_eff = restart ? PH_HEADER : phase_r;

  assign step_hdr = accept && (phase_eff == PH_HEADER);
  assign step_pix = accept && (phase_eff == PH_PIXELS);
  assign step_pad = accept && (phase_eff == PH_PAD || phase_eff == PH_TAIL_PAD);

  bmp24_hdr u_hdr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_hdr),
    .restart   (restart),
    .file_byte (in_word.file_byte),
    .info      (hdr)
  );

  // counters restart when the last header byte goes by
  bmp24_pix u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_hdr && hdr.done),
    .step_pix  (step_pix),
    .step_pad  (step_pad),
    .file_byte (in_word.file_byte),
    .hdr       (hdr),
    .info      (pix),
    .pixel     (pixel)
  );

  // next phase and the result of this byte
  always_comb begin
    phase_nxt = phase_eff;
    res_valid = 1'b0;
    res_word  = '0;
    unique case (phase_eff)
      PH_HEADER: begin
        if (hdr.err) begin
          phase_nxt       = PH_HALTED;
          res_valid       = 1'b1;
          res_word.status = hdr.err_code;
        end else if (hdr.done) begin
          phase_nxt = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (pix.emit) begin
          res_valid = 1'b1;
          res_word  = pixel;
          if (pix.row_end) begin
            if (pix.last) begin
              phase_nxt = (hdr.pad_bytes != 2'd0) ? PH_TAIL_PAD : PH_DONE;
            end else begin
              phase_nxt = (hdr.pad_bytes != 2'd0) ? PH_PAD : PH_PIXELS;
            end
          end
        end
      end
      PH_PAD, PH_TAIL_PAD: begin
        if (pix.pad_done) begin
          phase_nxt = (phase_eff == PH_PAD) ? PH_PIXELS : PH_DONE;
        end
        // nonzero padding is reported but decoding carries on
        if (in_word.file_byte != 8'd0) begin
          res_valid       = 1'b1;
          res_word.status = bmp24_pkg::ST_PAD_NONZERO;
        end
      end
      default: begin
        // done or halted: bytes are dropped until the next start flag
        phase_nxt = phase_eff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      out_valid_r <= res_valid;
      out_word_r  <= res_word;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* tb/bmp24_stream_checker.sv */
// result checker for the 24-bit bmp stream decoder: decodes accepted bytes and compares words
`timescale 1ns / 1ps

module bmp24_stream_checker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_ready,
  input  bmp24_pkg::in_word_t  in_word,
  input  wire logic           out_valid,
  input  wire logic           out_ready,
  input  bmp24_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  pending
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_PIXELS, PH_PAD, PH_TAIL_PAD, PH_DONE, PH_HALTED
  } parse_phase_t;

  parse_phase_t phase;
  logic [5:0]   hdr_pos;
  logic [31:0]  field_acc;
  logic [31:0]  img_width;
  logic [31:0]  img_height;
  logic [1:0]   chan;
  logic [7:0]   held_blue;
  logic [7:0]   held_green;
  logic [11:0]  col;
  logic [11:0]  row;
  logic [1:0]   pad_left;

  bmp24_pkg::out_word_t decoded_pixels[$];
  int                   words_seen = 0;

  function automatic void clear_parse();
    phase      = PH_HEADER;
    hdr_pos    = '0;
    field_acc  = '0;
    img_width  = '0;
    img_height = '0;
    chan       = '0;
    held_blue  = '0;
    held_green = '0;
    col        = '0;
    row        = '0;
    pad_left   = '0;
  endfunction

  function automatic bmp24_pkg::out_word_t halt(input logic [2:0] code);
    bmp24_pkg::out_word_t w;
    w = '0;
    w.status = code;
    phase = PH_HALTED;
    return w;
  endfunction

  // advances the parse by one byte, returns 1 when the byte yields a word
  function automatic bit decode_byte(input bmp24_pkg::in_word_t w,
                                     output bmp24_pkg::out_word_t res);
    logic [5:0] pos;
    logic       is_last;
    res = '0;
    if (w.start_of_file) clear_parse();
    case (phase)
      PH_HEADER: begin
        field_acc = {w.file_byte, field_acc[31:8]};
        pos = hdr_pos;
        hdr_pos = hdr_pos + 6'd1;
        if (pos == bmp24_pkg::POS_MAGIC && field_acc[31:16] != bmp24_pkg::MAGIC_LE) begin
          res = halt(bmp24_pkg::ST_BAD_MAGIC);
          return 1'b1;
        end
        if (pos == bmp24_pkg::POS_INFO_SIZE && field_acc != bmp24_pkg::INFO_SIZE) begin
          res = halt(bmp24_pkg::ST_BAD_HDR_SIZE);
          return 1'b1;
        end
        if (pos == bmp24_pkg::POS_WIDTH) img_width = field_acc;
        if (pos == bmp24_pkg::POS_HEIGHT) begin
          img_height = field_acc;
          if (img_width == 32'd0 || img_width > 32'(bmp24_pkg::MAX_WIDTH) ||
              img_height == 32'd0 || img_height > 32'(bmp24_pkg::MAX_HEIGHT)) begin
            res = halt(bmp24_pkg::ST_BAD_SIZE);
            return 1'b1;
          end
        end
        if (pos == bmp24_pkg::POS_PLANES && field_acc[31:16] != bmp24_pkg::ONE_PLANE) begin
          res = halt(bmp24_pkg::ST_BAD_PLANES);
          return 1'b1;
        end
        if (pos == bmp24_pkg::POS_COMPRESS && field_acc != 32'd0) begin
          res = halt(bmp24_pkg::ST_COMPRESSED);
          return 1'b1;
        end
        if (pos == bmp24_pkg::POS_HDR_LAST) begin
          phase    = PH_PIXELS;
          chan     = '0;
          col      = '0;
          row      = '0;
          pad_left = '0;
        end
        return 1'b0;
      end
      PH_PIXELS: begin
        if (chan == 2'd0) begin
          held_blue = w.file_byte;
          chan = 2'd1;
          return 1'b0;
        end
        if (chan == 2'd1) begin
          held_green = w.file_byte;
          chan = 2'd2;
          return 1'b0;
        end
        chan = 2'd0;
        is_last = ({20'd0, col} == img_width - 32'd1) && ({20'd0, row} == img_height - 32'd1);
        res.red        = w.file_byte;
        res.green      = held_green;
        res.blue       = held_blue;
        res.out_row    = 12'(img_height - 32'd1 - {20'd0, row});
        res.out_column = col;
        res.last_pixel = is_last;
        res.status     = bmp24_pkg::ST_PIXEL;
        if ({20'd0, col} == img_width - 32'd1) begin
          col = '0;
          pad_left = img_width[1:0];
          if (is_last) begin
            phase = (pad_left != 2'd0) ? PH_TAIL_PAD : PH_DONE;
          end else begin
            row = row + 12'd1;
            phase = (pad_left != 2'd0) ? PH_PAD : PH_PIXELS;
          end
        end else begin
          col = col + 12'd1;
        end
        return 1'b1;
      end
      PH_PAD, PH_TAIL_PAD: begin
        pad_left = pad_left - 2'd1;
        if (pad_left == 2'd0) phase = (phase == PH_PAD) ? PH_PIXELS : PH_DONE;
        if (w.file_byte != 8'd0) begin
          res.status = bmp24_pkg::ST_PAD_NONZERO;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("word %0d %s got %0d expected %0d", words_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    bmp24_pkg::out_word_t want;
    bmp24_pkg::out_word_t pix;
    if (!rst_n) begin
      clear_parse();
      decoded_pixels.delete();
    end else begin
      // words leave before the byte of this edge can add one
      if (out_valid && out_ready) begin
        if (decoded_pixels.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with none expected, status %0d",
                                    words_seen, out_word.status));
        end else begin
          want = decoded_pixels.pop_front();
          check_field("red", out_word.red, want.red);
          check_field("green", out_word.green, want.green);
          check_field("blue", out_word.blue, want.blue);
          check_field("out_row", out_word.out_row, want.out_row);
          check_field("out_column", out_word.out_column, want.out_column);
          check_field("last_pixel", out_word.last_pixel, want.last_pixel);
          check_field("status", out_word.status, want.status);
        end
        words_seen++;
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_word, pix)) decoded_pixels.push_back(pix);
      end
    end
    pending = decoded_pixels.size();
  end

endmodule

/* tb/tb.sv */
// testbench top for the 24-bit bmp stream decoder: file stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int LONG_HOLD   = 400;
  localparam int ITEM_TARGET = 1600;

  // one bmp file as the sender shapes it
  typedef struct {
    logic [15:0] magic;
    logic [31:0] info_size;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] planes;
    logic [31:0] compression;
    int          pad_noise;   // percent of padding bytes that are nonzero
    int          cut_at;      // bytes sent before the file is abandoned, -1 for all
    int          trailer;     // stray bytes after the file
    bit          flag_start;
  } bmp_file_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  bmp24_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_ready;
  bmp24_pkg::out_word_t out_word;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;
  int sent_bytes = 0;
  bit hold_request = 1'b0;
  bit flush = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bmp_24bit_stream_decoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  bmp24_stream_checker pixel_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: stall patterns in random spans, a long hold when asked, always ready at the end
  initial begin : result_sink
    int span;
    int mode;
    int k;
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (flush) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        span = $urandom_range(4, 60);
        mode = $urandom_range(0, 3);
        for (k = 0; k < span && !hold_request && !flush; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (k % 3 != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // one byte through the input handshake, bursts separated by random gaps
  task automatic send_byte(input logic [7:0] b, input bit sof);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= '{file_byte: b, start_of_file: sof};
    // ready is looked at mid-cycle, the word goes at the next rising edge
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sent_bytes++;
  endtask

  task automatic feed_byte(input logic [7:0] b, input bit sof, inout int n, input int cut_at);
    if (n != cut_at) begin
      send_byte(b, sof);
      n++;
    end
  endtask

  // sender idles until every predicted word has come out
  task automatic hold_until_decoded();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic bmp_file_t good_file(input int w, input int h);
    bmp_file_t f;
    f.magic       = bmp24_pkg::MAGIC_LE;
    f.info_size   = bmp24_pkg::INFO_SIZE;
    f.width       = 32'(w);
    f.height      = 32'(h);
    f.planes      = bmp24_pkg::ONE_PLANE;
    f.compression = 32'd0;
    f.pad_noise   = 0;
    f.cut_at      = -1;
    f.trailer     = 0;
    f.flag_start  = 1'b1;
    return f;
  endfunction

  task automatic send_bmp(input bmp_file_t f);
    logic [7:0] hdr [54];
    logic [15:0] bpp;
    bit sane;
    int n;
    int i;
    int r;
    int w;
    int h;
    // ignored fields carry random content
    foreach (hdr[j]) hdr[j] = 8'($urandom);
    bpp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd24;
    for (i = 0; i < 2; i++) begin
      hdr[i]      = f.magic[8*i +: 8];
      hdr[26 + i] = f.planes[8*i +: 8];
      hdr[28 + i] = bpp[8*i +: 8];
    end
    for (i = 0; i < 4; i++) begin
      hdr[10 + i] = 8'(32'd54 >> (8*i));
      hdr[14 + i] = f.info_size[8*i +: 8];
      hdr[18 + i] = f.width[8*i +: 8];
      hdr[22 + i] = f.height[8*i +: 8];
      hdr[30 + i] = f.compression[8*i +: 8];
    end
    sane = f.magic == bmp24_pkg::MAGIC_LE && f.info_size == bmp24_pkg::INFO_SIZE &&
           f.planes == bmp24_pkg::ONE_PLANE && f.compression == 32'd0 &&
           f.width >= 32'd1 && f.width <= 32'(bmp24_pkg::MAX_WIDTH) &&
           f.height >= 32'd1 && f.height <= 32'(bmp24_pkg::MAX_HEIGHT);
    n = 0;
    for (i = 0; i < 54; i++) feed_byte(hdr[i], f.flag_start && i == 0, n, f.cut_at);
    // pixel rows only behind a header the block accepts
    if (sane) begin
      w = int'(f.width);
      h = int'(f.height);
      for (r = 0; r < h && n != f.cut_at; r++) begin
        for (i = 0; i < 3 * w; i++) feed_byte(8'($urandom), 1'b0, n, f.cut_at);
        for (i = 0; i < w % 4; i++)
          feed_byte(($urandom_range(1, 100) <= f.pad_noise) ? 8'($urandom_range(1, 255)) : 8'h00,
                    1'b0, n, f.cut_at);
      end
    end
    for (i = 0; i < f.trailer; i++) feed_byte(8'($urandom), 1'b0, n, f.cut_at);
  endtask

  initial begin : stimulus
    bmp_file_t f;
    int kind;
    int i;
    bit sof;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // first file right after reset carries no start flag
    f = good_file(2, 2);
    f.flag_start = 1'b0;
    send_bmp(f);
    // each header check at least once
    f = good_file(3, 2);
    f.magic = 16'h424D;
    send_bmp(f);
    f = good_file(3, 2);
    f.info_size = 32'd12;
    send_bmp(f);
    send_bmp(good_file(0, 2));
    send_bmp(good_file(4097, 1));
    send_bmp(good_file(1, 0));
    send_bmp(good_file(1, 4097));
    // top-down file, negative height
    f = good_file(2, 2);
    f.height = 32'hFFFF_FFFE;
    send_bmp(f);
    f = good_file(2, 2);
    f.planes = 16'd2;
    send_bmp(f);
    f = good_file(2, 2);
    f.compression = 32'd1;
    f.trailer = 3;
    send_bmp(f);
    // every padding byte nonzero, row padding and tail padding
    f = good_file(3, 3);
    f.pad_noise = 100;
    f.trailer = 4;
    send_bmp(f);
    // start flag in the middle of the pixel data
    f = good_file(5, 2);
    f.cut_at = 70;
    send_bmp(f);
    send_bmp(good_file(4, 1));
    // largest accepted size, abandoned after the first pixels of the bottom row
    f = good_file(bmp24_pkg::MAX_WIDTH, bmp24_pkg::MAX_HEIGHT);
    f.cut_at = 54 + 3 * 16;
    send_bmp(f);
    hold_until_decoded();

    // long receiver hold while pixel bytes keep coming
    hold_request = 1'b1;
    send_bmp(good_file(8, 6));
    hold_until_decoded();

    while (sent_bytes < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      f = good_file(($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9),
                    $urandom_range(1, 5));
      f.pad_noise = ($urandom_range(0, 4) == 0) ? 30 : 0;
      f.trailer = $urandom_range(0, 3);
      if (kind < 65) begin
        send_bmp(f);
      end else if (kind < 80) begin
        case ($urandom_range(0, 6))
          0: f.magic = bmp24_pkg::MAGIC_LE ^ 16'($urandom_range(1, 65535));
          1: f.info_size = bmp24_pkg::INFO_SIZE ^ ($urandom | 32'd1);
          2: case ($urandom_range(0, 2))
               0: f.width = 32'd0;
               1: f.width = 32'(bmp24_pkg::MAX_WIDTH + 1 + $urandom_range(0, 100000));
               default: f.width = $urandom | 32'h8000_0000;
             endcase
          3: case ($urandom_range(0, 2))
               0: f.height = 32'd0;
               1: f.height = 32'(-$urandom_range(1, 4096));
               default: f.height = 32'(bmp24_pkg::MAX_HEIGHT + 1 + $urandom_range(0, 100000));
             endcase
          4: f.planes = bmp24_pkg::ONE_PLANE ^ 16'($urandom_range(1, 65535));
          5: f.compression = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 3)) :
                             ($urandom | 32'd1);
          default: begin
            f.magic = 16'($urandom);
            f.planes = 16'($urandom);
          end
        endcase
        send_bmp(f);
      end else if (kind < 90) begin
        f.cut_at = $urandom_range(1, 100);
        send_bmp(f);
      end else begin
        // loose bytes, sometimes opening a garbage header
        sof = $urandom_range(0, 1);
        for (i = $urandom_range(3, 30); i > 0; i--) send_byte(8'($urandom), sof && i == 1);
      end
      if ($urandom_range(0, 15) == 0) hold_until_decoded();
    end

    hold_until_decoded();
    flush = 1'b1;
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
